[src/tgat_pkg.sv]
// Shared types, widths and constants of the tilt and gyro angle tracker.
// Used by tgat_ctrl, tgat_dp and tilt_and_gyro_angle_tracker; depends on nothing.
`default_nettype none

package tgat_pkg;

  // Arctangent table length and the iteration counter that walks it.
  localparam int TABLE_LEN        = 24;
  localparam int CNT_W            = $clog2(TABLE_LEN);
  localparam int CORDIC_STEPS_DEF = 16;

  // Field widths.
  localparam int RAW_W   = 16;
  localparam int STAMP_W = 32;
  localparam int ELAP_W  = 16;
  localparam int TILT_W  = 24;
  localparam int ANGLE_W = 48;
  localparam int GAIN_W  = 16;
  localparam int BIAS_W  = 28;
  localparam int CFG_W   = 28;
  localparam int IDX_W   = 2;

  // Internal datapath widths.
  localparam int XY_W   = 36;  // CORDIC vector components, signed
  localparam int Z_W    = 25;  // CORDIC angle accumulator, signed
  localparam int ATAN_W = 23;  // table entries and clamped angle, unsigned
  localparam int PROD_W = 33;  // raw * gain and the biased rate, signed
  localparam int SCL_W  = 50;  // rate * elapsed, signed
  localparam int DVD_W  = 48;  // magnitude of rate * elapsed
  localparam int REM_W  = 10;  // remainder of the division by a thousand

  // Division by a thousand in sixteen-bit quotient digits.
  // Each partial dividend is below 2^26, so the reciprocal ceil(2^36 / 1000)
  // gives the exact digit.
  localparam int             DIG_W     = 16;
  localparam int             DIV_STEPS = 2 * (DVD_W / DIG_W);
  localparam int             X_W       = REM_W + DIG_W;
  localparam int             RCP_W     = 27;
  localparam int             RCP_P_W   = X_W + RCP_W;
  localparam int             RCP_SH    = 36;
  localparam logic [REM_W:0] MS_PER_S  = 11'd1000;
  localparam logic [RCP_W-1:0] MS_RECIP = 27'd68719477;

  localparam logic [ATAN_W-1:0]  NINETY_Q16 = 23'd5898240;
  localparam logic [ELAP_W-1:0]  ELAP_CAP   = 16'hFFFF;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic [ANGLE_W-1:0] ANGLE_MIN  = {1'b1, {(ANGLE_W-1){1'b0}}};

  // Register map and reset values.
  localparam logic [IDX_W-1:0]  REG_GAIN   = 2'd0;
  localparam logic [IDX_W-1:0]  REG_BIAS_X = 2'd1;
  localparam logic [IDX_W-1:0]  REG_BIAS_Y = 2'd2;
  localparam logic [IDX_W-1:0]  REG_BIAS_Z = 2'd3;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd4001;
  localparam logic [BIAS_W-1:0] BIAS_X_RST = -28'sd78381;
  localparam logic [BIAS_W-1:0] BIAS_Y_RST = -28'sd7583;
  localparam logic [BIAS_W-1:0] BIAS_Z_RST = 28'sd59802;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_GAIN,
    S_RATE,
    S_SCALE,
    S_DIV,
    S_ACC
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;         // capture an input beat
    logic cordic_step;  // one vectoring iteration on both tilt lanes
    logic gain;         // raw rate times gain
    logic rate;         // subtract the bias
    logic scale;        // times elapsed milliseconds
    logic div_step;     // half a quotient digit of the division by a thousand
    logic commit;       // update the angles and load the result beat
  } dp_cmd_t;

  // atan(2^-i) in Q16 degrees, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
    case (i)
      5'd0:    return 23'd2949120;
      5'd1:    return 23'd1740967;
      5'd2:    return 23'd919879;
      5'd3:    return 23'd466945;
      5'd4:    return 23'd234379;
      5'd5:    return 23'd117304;
      5'd6:    return 23'd58666;
      5'd7:    return 23'd29335;
      5'd8:    return 23'd14668;
      5'd9:    return 23'd7334;
      5'd10:   return 23'd3667;
      5'd11:   return 23'd1833;
      5'd12:   return 23'd917;
      5'd13:   return 23'd458;
      5'd14:   return 23'd229;
      5'd15:   return 23'd115;
      5'd16:   return 23'd57;
      5'd17:   return 23'd29;
      5'd18:   return 23'd14;
      5'd19:   return 23'd7;
      5'd20:   return 23'd4;
      5'd21:   return 23'd2;
      5'd22:   return 23'd1;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

[src/tilt_and_gyro_angle_tracker.sv]
// Top level of the tilt and gyro angle tracker: joins the sequencer and
// the datapath. Uses tgat_pkg, tgat_ctrl and tgat_dp.
//
//   Channel  Handshake             Beat contents
//   in_      in_valid / in_ready   accel_x/y/z, rate_x/y/z, now_ms
//   out_     out_valid / out_ready tilt_x/y, angle_x/y/z, elapsed_ms, saturated
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// From acceptance to a result beat, the two tilt lanes first iterate in step,
// then the three gyro lanes share the sequencer for gain, bias, scaling and a
// division by a thousand, one sixteen-bit quotient digit at a time.
// A new beat is taken in the cycle after the result is loaded, while that
// result still waits; the next result waits for the output register to empty.
// Reset is synchronous and restores the register defaults and clears the angles.
`default_nettype none

module tilt_and_gyro_angle_tracker
  import tgat_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [RAW_W-1:0]   in_accel_x,
  input  wire logic signed [RAW_W-1:0]   in_accel_y,
  input  wire logic signed [RAW_W-1:0]   in_accel_z,
  input  wire logic signed [RAW_W-1:0]   in_rate_x,
  input  wire logic signed [RAW_W-1:0]   in_rate_y,
  input  wire logic signed [RAW_W-1:0]   in_rate_z,
  input  wire logic        [STAMP_W-1:0] in_now_ms,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [TILT_W-1:0]  out_tilt_x,
  output      logic signed [TILT_W-1:0]  out_tilt_y,
  output      logic signed [ANGLE_W-1:0] out_angle_x,
  output      logic signed [ANGLE_W-1:0] out_angle_y,
  output      logic signed [ANGLE_W-1:0] out_angle_z,
  output      logic        [ELAP_W-1:0]  out_elapsed_ms,
  output      logic                      out_saturated,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic        [IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_W-1:0]   cfg_data
);

  dp_cmd_t          cmd;
  logic [CNT_W-1:0] cnt;

  // Register writes are never stalled.
  assign cfg_ready = 1'b1;

  // Sequencer.
  tgat_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  // Datapath.
  tgat_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .in_now_ms     (in_now_ms),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .cnt           (cnt),
    .out_tilt_x    (out_tilt_x),
    .out_tilt_y    (out_tilt_y),
    .out_angle_x   (out_angle_x),
    .out_angle_y   (out_angle_y),
    .out_angle_z   (out_angle_z),
    .out_elapsed_ms(out_elapsed_ms),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

[src/tgat_ctrl.sv]
// Sequencer of the tilt and gyro angle tracker: steps the datapath through
// the tilt iterations, the gyro scaling and the division. Uses tgat_pkg.
`default_nettype none

module tgat_ctrl
  import tgat_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      dp_cmd_t          cmd,
  output      logic [CNT_W-1:0] cnt
);

  localparam int STEPS_USED = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(STEPS_USED - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  // The result register may be reloaded when it is empty or being emptied.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and iteration count.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CORDIC;
          cnt_nxt   = '0;
        end
      end
      S_CORDIC: begin
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = S_GAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GAIN:  state_nxt = S_RATE;
      S_RATE:  state_nxt = S_SCALE;
      S_SCALE: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CORDIC: cmd.cordic_step = 1'b1;
      S_GAIN:   cmd.gain        = 1'b1;
      S_RATE:   cmd.rate        = 1'b1;
      S_SCALE:  cmd.scale       = 1'b1;
      S_DIV:    cmd.div_step    = 1'b1;
      S_ACC:    cmd.commit      = slot_free;
      default:  cmd             = '0;
    endcase
  end

  // Result beat is held until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

endmodule

`default_nettype wire

[src/tgat_dp.sv]
// Datapath of the tilt and gyro angle tracker: configuration registers, two
// CORDIC tilt lanes, three gyro lanes with a reciprocal divider, result register.
// Uses tgat_pkg; driven by tgat_ctrl.
`default_nettype none

module tgat_dp
  import tgat_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic signed [RAW_W-1:0]   in_accel_x,
  input  wire logic signed [RAW_W-1:0]   in_accel_y,
  input  wire logic signed [RAW_W-1:0]   in_accel_z,
  input  wire logic signed [RAW_W-1:0]   in_rate_x,
  input  wire logic signed [RAW_W-1:0]   in_rate_y,
  input  wire logic signed [RAW_W-1:0]   in_rate_z,
  input  wire logic        [STAMP_W-1:0] in_now_ms,
  input  wire logic                      cfg_valid,
  input  wire logic        [IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_W-1:0]   cfg_data,
  input  wire dp_cmd_t                   cmd,
  input  wire logic        [CNT_W-1:0]   cnt,
  output      logic signed [TILT_W-1:0]  out_tilt_x,
  output      logic signed [TILT_W-1:0]  out_tilt_y,
  output      logic signed [ANGLE_W-1:0] out_angle_x,
  output      logic signed [ANGLE_W-1:0] out_angle_y,
  output      logic signed [ANGLE_W-1:0] out_angle_z,
  output      logic        [ELAP_W-1:0]  out_elapsed_ms,
  output      logic                      out_saturated
);

  // Configuration and tracking state.
  logic        [GAIN_W-1:0]  gain_r;
  logic signed [BIAS_W-1:0]  bias_r [3];
  logic        [STAMP_W-1:0] last_stamp_r;
  logic signed [ANGLE_W-1:0] angle_r [3];

  // Captured beat.
  logic signed [RAW_W-1:0]  num_r [2];
  logic signed [RAW_W-1:0]  den_r;
  logic signed [RAW_W-1:0]  raw_r [3];
  logic        [ELAP_W-1:0] elapsed_r;

  // Tilt lanes.
  logic signed [XY_W-1:0] cx_r [2];
  logic signed [XY_W-1:0] cy_r [2];
  logic signed [Z_W-1:0]  cz_r [2];
  logic signed [XY_W-1:0] cx_nxt [2];
  logic signed [XY_W-1:0] cy_nxt [2];
  logic signed [Z_W-1:0]  cz_nxt [2];
  logic        [RAW_W:0]  num_abs [2];
  logic        [RAW_W:0]  den_abs;

  // Gyro lanes.
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [PROD_W-1:0]  rate_r [3];
  logic        [DVD_W-1:0]   dvd_r [3];
  logic        [REM_W-1:0]   rem_r [3];
  logic        [DIG_W-1:0]   qd_r [3];
  logic                      psign_r [3];
  logic        [X_W-1:0]     part [3];
  logic        [DIG_W-1:0]   qd_nxt [3];
  logic        [REM_W-1:0]   rem_nxt [3];
  logic signed [SCL_W-1:0]   scaled [3];
  logic signed [ANGLE_W:0]   sum [3];
  logic signed [ANGLE_W-1:0] acc_nxt [3];
  logic        [2:0]         clip;

  // Elapsed time since the previous beat, capped.
  logic [STAMP_W-1:0] span;
  logic [ELAP_W-1:0]  elapsed_new;

  // Result register.
  logic signed [TILT_W-1:0] tilt_out_r [2];
  logic        [ELAP_W-1:0] elapsed_out_r;
  logic                     sat_out_r;

  // Final tilt angle from the lane's angle, with the special cases.
  function automatic logic [TILT_W-1:0] tilt_final(input logic signed [RAW_W-1:0] num,
                                                   input logic signed [RAW_W-1:0] den,
                                                   input logic signed [Z_W-1:0]   z);
    logic [ATAN_W-1:0] zc;
    logic [TILT_W-1:0] mag;
    if (z[Z_W-1]) begin
      zc = '0;
    end else if (z > $signed({2'b00, NINETY_Q16})) begin
      zc = NINETY_Q16;
    end else begin
      zc = z[ATAN_W-1:0];
    end
    mag = {1'b0, zc};
    if (den == '0) begin
      if (num == '0) begin
        return '0;
      end else if (num[RAW_W-1]) begin
        return -{1'b0, NINETY_Q16};
      end else begin
        return {1'b0, NINETY_Q16};
      end
    end else if (num == '0) begin
      return '0;
    end else if (num[RAW_W-1] ^ den[RAW_W-1]) begin
      return -mag;
    end else begin
      return mag;
    end
  endfunction

  // Configuration writes; unlisted bits of the gain write are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RST;
      bias_r[0] <= BIAS_X_RST;
      bias_r[1] <= BIAS_Y_RST;
      bias_r[2] <= BIAS_Z_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:   gain_r    <= cfg_data[GAIN_W-1:0];
        REG_BIAS_X: bias_r[0] <= cfg_data;
        REG_BIAS_Y: bias_r[1] <= cfg_data;
        REG_BIAS_Z: bias_r[2] <= cfg_data;
        default:    gain_r    <= gain_r;
      endcase
    end
  end

  // Input capture and elapsed time.
  assign span        = in_now_ms - last_stamp_r;
  assign elapsed_new = (|span[STAMP_W-1:ELAP_W]) ? ELAP_CAP : span[ELAP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
    end else if (cmd.load) begin
      last_stamp_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r[0]  <= in_accel_x;
      num_r[1]  <= in_accel_y;
      den_r     <= in_accel_z;
      raw_r[0]  <= in_rate_x;
      raw_r[1]  <= in_rate_y;
      raw_r[2]  <= in_rate_z;
      elapsed_r <= elapsed_new;
    end
  end

  // Magnitudes that seed the vectoring iterations.
  always_comb begin
    den_abs = in_accel_z[RAW_W-1] ? -{in_accel_z[RAW_W-1], in_accel_z}
                                  : {1'b0, in_accel_z};
    num_abs[0] = in_accel_x[RAW_W-1] ? -{in_accel_x[RAW_W-1], in_accel_x}
                                     : {1'b0, in_accel_x};
    num_abs[1] = in_accel_y[RAW_W-1] ? -{in_accel_y[RAW_W-1], in_accel_y}
                                     : {1'b0, in_accel_y};
  end

  // One vectoring iteration per lane: rotate towards the x axis.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!cy_r[l][XY_W-1]) begin
        cx_nxt[l] = cx_r[l] + (cy_r[l] >>> cnt);
        cy_nxt[l] = cy_r[l] - (cx_r[l] >>> cnt);
        cz_nxt[l] = cz_r[l] + $signed({2'b00, atan_q16(cnt)});
      end else begin
        cx_nxt[l] = cx_r[l] - (cy_r[l] >>> cnt);
        cy_nxt[l] = cy_r[l] + (cx_r[l] >>> cnt);
        cz_nxt[l] = cz_r[l] - $signed({2'b00, atan_q16(cnt)});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.load) begin
        cx_r[l] <= {3'b000, den_abs, 16'h0000};
        cy_r[l] <= {3'b000, num_abs[l], 16'h0000};
        cz_r[l] <= '0;
      end else if (cmd.cordic_step) begin
        cx_r[l] <= cx_nxt[l];
        cy_r[l] <= cy_nxt[l];
        cz_r[l] <= cz_nxt[l];
      end
    end
  end

  // Division by a thousand, one sixteen-bit quotient digit at a time:
  // the partial dividend times the scaled reciprocal gives the digit, then the
  // digit times a thousand taken from the partial dividend gives the remainder.
  always_comb begin
    logic [RCP_P_W-1:0] rp;
    logic [X_W-1:0]     back;
    for (int k = 0; k < 3; k++) begin
      part[k]    = {rem_r[k], dvd_r[k][DVD_W-1 -: DIG_W]};
      rp         = RCP_P_W'(part[k]) * RCP_P_W'(MS_RECIP);
      qd_nxt[k]  = rp[RCP_SH +: DIG_W];
      back       = X_W'(qd_r[k]) * X_W'(MS_PER_S);
      rem_nxt[k] = REM_W'(part[k] - back);
    end
  end

  // Rate times elapsed, then the signed quotient added with saturation.
  always_comb begin
    logic signed [ANGLE_W:0] q;
    for (int k = 0; k < 3; k++) begin
      scaled[k] = SCL_W'(rate_r[k]) * SCL_W'($signed({1'b0, elapsed_r}));
      q         = psign_r[k] ? -$signed({1'b0, dvd_r[k]}) : $signed({1'b0, dvd_r[k]});
      sum[k]    = {angle_r[k][ANGLE_W-1], angle_r[k]} + q;
      clip[k]   = sum[k][ANGLE_W] != sum[k][ANGLE_W-1];
      if (!clip[k]) begin
        acc_nxt[k] = sum[k][ANGLE_W-1:0];
      end else if (sum[k][ANGLE_W]) begin
        acc_nxt[k] = ANGLE_MIN;
      end else begin
        acc_nxt[k] = ANGLE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.gain) begin
        prod_r[k] <= PROD_W'(raw_r[k]) * PROD_W'($signed({1'b0, gain_r}));
      end
      if (cmd.rate) begin
        rate_r[k] <= prod_r[k] - PROD_W'(bias_r[k]);
      end
      if (cmd.scale) begin
        psign_r[k] <= scaled[k][SCL_W-1];
        dvd_r[k]   <= scaled[k][SCL_W-1] ? DVD_W'(-scaled[k]) : DVD_W'(scaled[k]);
        rem_r[k]   <= '0;
      end else if (cmd.div_step) begin
        if (!cnt[0]) begin
          qd_r[k] <= qd_nxt[k];
        end else begin
          dvd_r[k] <= {dvd_r[k][DVD_W-DIG_W-1:0], qd_r[k]};
          rem_r[k] <= rem_nxt[k];
        end
      end
    end
  end

  // Gyro angle accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        angle_r[k] <= '0;
      end
    end else if (cmd.commit) begin
      for (int k = 0; k < 3; k++) begin
        angle_r[k] <= acc_nxt[k];
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tilt_out_r[0] <= tilt_final(num_r[0], den_r, cz_r[0]);
      tilt_out_r[1] <= tilt_final(num_r[1], den_r, cz_r[1]);
      elapsed_out_r <= elapsed_r;
      sat_out_r     <= |clip;
    end
  end

  assign out_tilt_x     = tilt_out_r[0];
  assign out_tilt_y     = tilt_out_r[1];
  assign out_angle_x    = angle_r[0];
  assign out_angle_y    = angle_r[1];
  assign out_angle_z    = angle_r[2];
  assign out_elapsed_ms = elapsed_out_r;
  assign out_saturated  = sat_out_r;

endmodule

`default_nettype wire

[bench/tgat_angle_checker.sv]
// Checker for the tilt and gyro angle tracker: watches the sample, result and
// register channels, predicts every result beat and compares it field by field.
// Depends on tgat_pkg for widths and register indexes.

module tgat_angle_checker
  import tgat_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [RAW_W-1:0]   in_accel_x,
  input  wire logic signed [RAW_W-1:0]   in_accel_y,
  input  wire logic signed [RAW_W-1:0]   in_accel_z,
  input  wire logic signed [RAW_W-1:0]   in_rate_x,
  input  wire logic signed [RAW_W-1:0]   in_rate_y,
  input  wire logic signed [RAW_W-1:0]   in_rate_z,
  input  wire logic        [STAMP_W-1:0] in_now_ms,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic signed [TILT_W-1:0]  out_tilt_x,
  input  wire logic signed [TILT_W-1:0]  out_tilt_y,
  input  wire logic signed [ANGLE_W-1:0] out_angle_x,
  input  wire logic signed [ANGLE_W-1:0] out_angle_y,
  input  wire logic signed [ANGLE_W-1:0] out_angle_z,
  input  wire logic        [ELAP_W-1:0]  out_elapsed_ms,
  input  wire logic                      out_saturated,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic        [IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_W-1:0]   cfg_data,
  output int                             outstanding,
  output int                             mismatches
);

  // One result beat as the tracker should deliver it.
  typedef struct packed {
    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
    logic        [ELAP_W-1:0]  elapsed_ms;
    logic                      saturated;
  } tracker_beat_t;

  localparam int     ITERATIONS   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam longint RIGHT_ANGLE  = 5898240;
  localparam longint ANGLE_TOP    = 64'sd140737488355327;
  localparam longint ANGLE_BOTTOM = -ANGLE_TOP - 1;

  // Arctangent of 2^-i in Q16 degrees.
  longint atan_deg_q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Register copies and integration state.
  logic [GAIN_W-1:0]  gain_q16;
  longint             bias_q16 [3];
  logic [STAMP_W-1:0] prev_stamp;
  longint             gyro_sum [3];
  tracker_beat_t      expected_beats [$];

  // Vectoring arctangent of num/den in Q16 degrees, clamped to a right angle.
  function automatic logic signed [TILT_W-1:0] cordic_tilt(input longint num,
                                                           input longint den);
    longint vx;
    longint vy;
    longint ang;
    longint nx;
    int     i;
    if (den == 0) begin
      if (num > 0) return TILT_W'(RIGHT_ANGLE);
      if (num < 0) return TILT_W'(-RIGHT_ANGLE);
      return '0;
    end
    if (num == 0) return '0;
    vx  = (den < 0 ? -den : den) * 65536;
    vy  = (num < 0 ? -num : num) * 65536;
    ang = 0;
    for (i = 0; i < ITERATIONS; i++) begin
      if (vy >= 0) begin
        nx  = vx + (vy >>> i);
        vy  = vy - (vx >>> i);
        ang = ang + atan_deg_q16[i];
      end else begin
        nx  = vx - (vy >>> i);
        vy  = vy + (vx >>> i);
        ang = ang - atan_deg_q16[i];
      end
      vx = nx;
    end
    if (ang < 0) ang = 0;
    if (ang > RIGHT_ANGLE) ang = RIGHT_ANGLE;
    if ((num < 0) != (den < 0)) ang = -ang;
    return TILT_W'(ang);
  endfunction

  // Works out the result of one sample and moves the integration state on.
  function automatic tracker_beat_t advance_tracker(
      input logic signed [RAW_W-1:0] ax, input logic signed [RAW_W-1:0] ay,
      input logic signed [RAW_W-1:0] az, input logic signed [RAW_W-1:0] rx,
      input logic signed [RAW_W-1:0] ry, input logic signed [RAW_W-1:0] rz,
      input logic [STAMP_W-1:0] now);
    tracker_beat_t           b;
    logic [STAMP_W-1:0]      span;
    longint                  elapsed;
    longint                  rate;
    longint                  acc;
    logic signed [RAW_W-1:0] raws [3];
    int                      k;
    raws    = '{rx, ry, rz};
    span    = now - prev_stamp;
    elapsed = (span > 32'hFFFF) ? 65535 : longint'(span);
    b.saturated = 1'b0;
    for (k = 0; k < 3; k++) begin
      rate = longint'(raws[k]) * longint'(gain_q16) - bias_q16[k];
      acc  = gyro_sum[k] + (rate * elapsed) / 1000;
      if (acc > ANGLE_TOP) begin
        acc         = ANGLE_TOP;
        b.saturated = 1'b1;
      end
      if (acc < ANGLE_BOTTOM) begin
        acc         = ANGLE_BOTTOM;
        b.saturated = 1'b1;
      end
      gyro_sum[k] = acc;
    end
    prev_stamp   = now;
    b.tilt_x     = cordic_tilt(ax, az);
    b.tilt_y     = cordic_tilt(ay, az);
    b.angle_x    = ANGLE_W'(gyro_sum[0]);
    b.angle_y    = ANGLE_W'(gyro_sum[1]);
    b.angle_z    = ANGLE_W'(gyro_sum[2]);
    b.elapsed_ms = ELAP_W'(elapsed);
    return b;
  endfunction

  function automatic void check_field(input string field, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  initial mismatches = 0;

  // Register writes, sample beats and result beats, all seen at the clock edge.
  always @(posedge clk) begin : watch
    tracker_beat_t want;
    if (!rst_n) begin
      gain_q16   = 16'd4001;
      bias_q16   = '{-78381, -7583, 59802};
      prev_stamp = '0;
      gyro_sum   = '{0, 0, 0};
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:   gain_q16    = cfg_data[GAIN_W-1:0];
          REG_BIAS_X: bias_q16[0] = longint'($signed(cfg_data));
          REG_BIAS_Y: bias_q16[1] = longint'($signed(cfg_data));
          REG_BIAS_Z: bias_q16[2] = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat arrived with no sample outstanding");
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("tilt_x", want.tilt_x, out_tilt_x);
          check_field("tilt_y", want.tilt_y, out_tilt_y);
          check_field("angle_x", want.angle_x, out_angle_x);
          check_field("angle_y", want.angle_y, out_angle_y);
          check_field("angle_z", want.angle_z, out_angle_z);
          check_field("elapsed_ms", want.elapsed_ms, out_elapsed_ms);
          check_field("saturated", want.saturated, out_saturated);
        end
      end
      if (in_valid && in_ready) begin
        expected_beats.push_back(advance_tracker(in_accel_x, in_accel_y, in_accel_z,
                                                 in_rate_x, in_rate_y, in_rate_z,
                                                 in_now_ms));
      end
    end
    outstanding <= expected_beats.size();
  end

endmodule

[bench/tb_top.sv]
// Top of the tilt and gyro angle tracker testbench: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on tgat_pkg, tilt_and_gyro_angle_tracker and tgat_angle_checker.

module tb_top;
  import tgat_pkg::*;

  localparam int CORDIC_STEPS   = CORDIC_STEPS_DEF;
  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRIFT_BEATS    = 1050;
  localparam int TAIL_CYCLES    = CORDIC_STEPS + 24;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic signed [RAW_W-1:0]   in_accel_x = '0;
  logic signed [RAW_W-1:0]   in_accel_y = '0;
  logic signed [RAW_W-1:0]   in_accel_z = '0;
  logic signed [RAW_W-1:0]   in_rate_x  = '0;
  logic signed [RAW_W-1:0]   in_rate_y  = '0;
  logic signed [RAW_W-1:0]   in_rate_z  = '0;
  logic        [STAMP_W-1:0] in_now_ms  = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic signed [TILT_W-1:0]  out_tilt_x;
  logic signed [TILT_W-1:0]  out_tilt_y;
  logic signed [ANGLE_W-1:0] out_angle_x;
  logic signed [ANGLE_W-1:0] out_angle_y;
  logic signed [ANGLE_W-1:0] out_angle_z;
  logic        [ELAP_W-1:0]  out_elapsed_ms;
  logic                      out_saturated;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic        [IDX_W-1:0]   cfg_index  = '0;
  logic        [CFG_W-1:0]   cfg_data   = '0;

  int                 outstanding;
  int                 mismatches;
  int                 idle_pct  = 0;
  int                 stall_pct = 0;
  logic               hold_req  = 1'b0;
  int                 hold_left = 0;
  logic [STAMP_W-1:0] stamp     = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  tilt_and_gyro_angle_tracker #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_accel_x, .in_accel_y, .in_accel_z,
    .in_rate_x, .in_rate_y, .in_rate_z, .in_now_ms,
    .out_valid, .out_ready,
    .out_tilt_x, .out_tilt_y, .out_angle_x, .out_angle_y, .out_angle_z,
    .out_elapsed_ms, .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tgat_angle_checker #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .in_accel_x, .in_accel_y, .in_accel_z,
    .in_rate_x, .in_rate_y, .in_rate_z, .in_now_ms,
    .out_valid, .out_ready,
    .out_tilt_x, .out_tilt_y, .out_angle_x, .out_angle_y, .out_angle_z,
    .out_elapsed_ms, .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .outstanding, .mismatches
  );

  // Result back-pressure: random stalls, or a long hold-off once requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one sample beat after a random gap and waits until it is taken.
  task automatic send_sample(input logic signed [RAW_W-1:0] ax,
                             input logic signed [RAW_W-1:0] ay,
                             input logic signed [RAW_W-1:0] az,
                             input logic signed [RAW_W-1:0] rx,
                             input logic signed [RAW_W-1:0] ry,
                             input logic signed [RAW_W-1:0] rz,
                             input logic [STAMP_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_rate_x  <= rx;
    in_rate_y  <= ry;
    in_rate_z  <= rz;
    in_now_ms  <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // Raw sensor value weighted towards zero, the extremes and tiny magnitudes.
  function automatic logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'sh8000;
      2:       return 16'sh7FFF;
      3:       return RAW_W'($urandom_range(6)) - RAW_W'(3);
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // Next timestamp: repeats, short steps, the cap boundary, jumps and wraps.
  function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] prev);
    case ($urandom_range(9))
      0:       return prev;
      1:       return prev + 32'd65535;
      2:       return prev + 32'd65536;
      3:       return prev + $urandom_range(1 << 20);
      4:       return $urandom();
      default: return prev + $urandom_range(200, 1);
    endcase
  endfunction

  task automatic send_random();
    stamp = next_stamp(stamp);
    send_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                stamp);
  endtask

  // Near full-scale rates of opposite sign on X and Y over capped intervals,
  // so that both accumulators run into their limits.
  task automatic send_drift();
    stamp = stamp + 32'd65535 + $urandom_range(50000);
    send_sample(pick_raw(), pick_raw(), pick_raw(),
                16'sh7FFF - RAW_W'($urandom_range(700)),
                16'sh8000 + RAW_W'($urandom_range(700)),
                pick_raw(), stamp);
  endtask

  // Stops offering samples and waits until every result beat has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all four registers; the unused upper bits of the gain beat are random.
  task automatic program_tracker(input logic [GAIN_W-1:0] gain,
                                 input logic [BIAS_W-1:0] bx,
                                 input logic [BIAS_W-1:0] by,
                                 input logic [BIAS_W-1:0] bz);
    write_reg(REG_GAIN, {(CFG_W - GAIN_W)'($urandom()), gain});
    write_reg(REG_BIAS_X, bx);
    write_reg(REG_BIAS_Y, by);
    write_reg(REG_BIAS_Z, bz);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Main stimulus sequence.
  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset register values.
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    send_sample(16'sd1000, -16'sd1000, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 32'd10);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd20);
    send_sample(16'sd0, 16'sd0, 16'sd500, 16'sh8000, 16'sh7FFF, 16'sh8000, 32'd30);
    send_sample(16'sd0, 16'sd0, -16'sd500, 16'sd0, 16'sd0, 16'sd0, 32'd31);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sd100, 16'sd200, 16'sd300, 32'd40);
    send_sample(16'sh8000, 16'sd1, 16'sd1, -16'sd100, -16'sd200, -16'sd300, 32'd50);
    send_sample(16'sd1, -16'sd1, 16'sh8000, 16'sd7, 16'sd7, 16'sd7, 32'd60);
    send_sample(16'sd1, 16'sd1, 16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd65595);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                32'd131131);
    send_sample(16'sd3, -16'sd4, 16'sd4, 16'sd12, -16'sd34, 16'sd56, 32'd100);
    send_sample(-16'sd4, 16'sd3, -16'sd4, 16'sd1, 16'sd1, 16'sd1, 32'hFFFF_FFFF);
    send_sample(16'sd9, 16'sd9, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 32'd5);
    send_sample(-16'sd1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sh8000, 32'd5);
    stamp = 32'd5;
    settle();

    // Long hold-off on the result side while samples keep coming.
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (n = 0; n < 20; n++) send_random();
    settle();

    // Unit gain, extreme biases; sender mostly idle.
    program_tracker(16'd1, 28'h800_0000, 28'h7FF_FFFF, 28'h000_0000);
    idle_pct = 80;
    for (n = 0; n < 320; n++) send_random();
    settle();

    // Zero gain, so the rate is the negated bias; receiver mostly stalling.
    program_tracker(16'd0, 28'h7FF_FFFF, 28'h800_0000, 28'($urandom()));
    idle_pct = 0;
    stall_pct <= 80;
    for (n = 0; n < 320; n++) send_random();
    settle();

    // Largest gain and biases that drive the accumulators into saturation.
    program_tracker(16'hFFFF, 28'h800_0000, 28'h7FF_FFFF, 28'($urandom()));
    idle_pct = 10;
    stall_pct <= 10;
    for (n = 0; n < DRIFT_BEATS; n++) send_drift();
    settle();

    // Random settings, no idling on either side.
    program_tracker(16'($urandom()), 28'($urandom()), 28'($urandom()), 28'($urandom()));
    idle_pct = 0;
    stall_pct <= 0;
    for (n = 0; n < 220; n++) send_random();
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
